@@ hw/rtl/wpqa_pkg.sv @@
// ----------------------------------------------------------------------------
// wpqa_pkg
// Shared types, sizes and codes of the weighted priority queue arbiter.
// ----------------------------------------------------------------------------
package wpqa_pkg;

    localparam int PendingDepth = 16;
    localparam int PendAw       = $clog2(PendingDepth);
    localparam int PendCw       = $clog2(PendingDepth + 1);
    localparam int SlotW        = PendAw + 1;
    localparam int NumClasses   = 4;
    localparam int ClsW         = 2;
    localparam int RamAw        = ClsW + PendAw;
    localparam int RamDepth     = NumClasses * (1 << PendAw);
    localparam int TagW         = 8;
    localparam int WeightW      = 8;
    localparam int CreditW      = 8;
    localparam int TotalW       = 10;
    localparam int CreditMax    = 255;
    localparam int TotalMax     = 1023;
    localparam int ApbAw        = 4;
    localparam int ApbDw        = 32;

    localparam logic [ClsW-1:0] ClsUrgent = 2'd0;
    localparam logic [ClsW-1:0] ClsHigh   = 2'd1;
    localparam logic [ClsW-1:0] ClsMedium = 2'd2;
    localparam logic [ClsW-1:0] ClsLow    = 2'd3;

    localparam logic CmdEnqueue = 1'b0;
    localparam logic CmdDone    = 1'b1;

    localparam logic [1:0] RegHighWeight   = 2'd0;
    localparam logic [1:0] RegMediumWeight = 2'd1;
    localparam logic [1:0] RegLowWeight    = 2'd2;

    typedef struct packed {
        logic            command;
        logic [2:0]      queue_number;
        logic [TagW-1:0] request_tag;
    } t_in_item;

    typedef struct packed {
        logic            launch_valid;
        logic [TagW-1:0] launch_tag;
        logic            delivered_valid;
        logic [TagW-1:0] delivered_tag;
        logic            overflow_flag;
        logic            underrun_flag;
    } t_out_item;

    typedef struct packed {
        logic            is_done;
        logic [ClsW-1:0] cls;
        logic [TagW-1:0] tag;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

    typedef struct packed {
        logic [WeightW-1:0] high;
        logic [WeightW-1:0] mid;
        logic [WeightW-1:0] low;
    } t_weights;

    typedef enum logic {
        BK_IDLE,
        BK_LAUNCH
    } t_back_state;

endpackage

@@ hw/rtl/wpqa_ram.sv @@
// ----------------------------------------------------------------------------
// wpqa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpqa_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/wpqa_front.sv @@
// ----------------------------------------------------------------------------
// wpqa_front
// Accepts input items, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module wpqa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wpqa_pkg::t_in_item  i_in_item,
    output wpqa_pkg::t_cmd_q    o_cmd_q,
    input  logic                i_cmd_pop
);

    wpqa_pkg::t_cmd r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_cnt;
    logic           push;
    logic           pop;
    wpqa_pkg::t_cmd new_cmd;

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_cmd_pop && (r_cnt != 2'd0);

    always_comb begin
        new_cmd.is_done = (i_in_item.command == wpqa_pkg::CmdDone);
        new_cmd.cls     = i_in_item.queue_number[wpqa_pkg::ClsW-1:0];
        new_cmd.tag     = i_in_item.request_tag;
    end

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= new_cmd;
        end
    end

    assign o_cmd_q.valid = (r_cnt != 2'd0);
    assign o_cmd_q.cmd   = r_q[r_rd_ptr];

endmodule

@@ hw/rtl/wpqa_back.sv @@
// ----------------------------------------------------------------------------
// wpqa_back
// Executes queued commands against the class FIFOs, the in-flight FIFO and
// the weighted round state, and holds the result in an output register.
// ----------------------------------------------------------------------------
module wpqa_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wpqa_pkg::t_cmd_q    i_cmd_q,
    output logic                o_cmd_pop,
    input  wpqa_pkg::t_weights  i_weights,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wpqa_pkg::t_out_item o_out_item
);

    localparam int PendAw = wpqa_pkg::PendAw;
    localparam int PendCw = wpqa_pkg::PendCw;
    localparam int SlotW  = wpqa_pkg::SlotW;
    localparam int TagW   = wpqa_pkg::TagW;
    localparam int CrW    = wpqa_pkg::CreditW;
    localparam int TotW   = wpqa_pkg::TotalW;
    localparam int NumCls = wpqa_pkg::NumClasses;
    localparam int RamAw  = wpqa_pkg::RamAw;

    wpqa_pkg::t_back_state r_state;
    wpqa_pkg::t_back_state n_state;

    logic [TagW-1:0]   r_fl_tag [2];
    logic              r_fl_head;
    logic [1:0]        r_fl_cnt;
    logic [PendAw-1:0] r_pend_head [NumCls];
    logic [PendCw-1:0] r_pend_cnt [NumCls];
    logic [CrW-1:0]    r_credit [NumCls];
    logic [TotW-1:0]   r_total;
    logic [TagW-1:0]   r_del_tag;
    logic              r_out_valid;
    wpqa_pkg::t_out_item r_out;

    logic [TagW-1:0]   n_fl_tag [2];
    logic              n_fl_head;
    logic [1:0]        n_fl_cnt;
    logic [PendAw-1:0] n_pend_head [NumCls];
    logic [PendCw-1:0] n_pend_cnt [NumCls];
    logic [CrW-1:0]    n_credit [NumCls];
    logic [TotW-1:0]   n_total;
    logic [TagW-1:0]   n_del_tag;
    logic              n_out_valid;
    wpqa_pkg::t_out_item n_out;

    logic              ram_we;
    logic [RamAw-1:0]  ram_waddr;
    logic [RamAw-1:0]  ram_raddr;
    logic [TagW-1:0]   ram_rdata;

    logic              out_free;
    logic              start;
    wpqa_pkg::t_cmd    cmd;
    logic [NumCls-1:0] pend_ne;
    logic [TotW-1:0]   wsum;
    logic              round_reset;
    logic [CrW-1:0]    cr [NumCls];
    logic [TotW-1:0]   tot0;
    logic [TotW-1:0]   tot1;
    logic              pick_high;
    logic              pick_med;
    logic              pick_low;
    logic              pick_any;
    logic [1:0]        pick_cls;
    logic [CrW-1:0]    p_credit [NumCls];
    logic [TotW-1:0]   p_total;
    logic [SlotW-1:0]  slot_sum;
    logic [PendAw-1:0] wr_slot;
    logic [PendAw-1:0] head_inc;
    logic              launches;

    function automatic logic [TotW-1:0] sat_total(input logic [TotW-1:0] a,
                                                  input logic [TotW-1:0] b);
        logic [TotW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > (TotW + 1)'(wpqa_pkg::TotalMax)) begin
            return TotW'(wpqa_pkg::TotalMax);
        end
        return s[TotW-1:0];
    endfunction

    function automatic logic [CrW-1:0] sat_credit(input logic [CrW-1:0] a);
        if (a == CrW'(wpqa_pkg::CreditMax)) begin
            return a;
        end
        return a + CrW'(1);
    endfunction

    wpqa_ram #(
        .Width(TagW),
        .Depth(wpqa_pkg::RamDepth)
    ) u_pend_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(cmd.tag),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign cmd       = i_cmd_q.cmd;
    assign out_free  = !r_out_valid || i_out_ready;
    assign start     = (r_state == wpqa_pkg::BK_IDLE) && i_cmd_q.valid && out_free;
    assign o_cmd_pop = start;

    always_comb begin
        for (int c = 0; c < NumCls; c++) begin
            pend_ne[c] = (r_pend_cnt[c] != '0);
        end
        wsum = TotW'(i_weights.high) + TotW'(i_weights.mid) + TotW'(i_weights.low);
        round_reset = (r_total >= wsum);
        for (int c = 0; c < NumCls; c++) begin
            cr[c] = round_reset ? '0 : r_credit[c];
        end
        tot0 = round_reset ? '0 : r_total;
        pick_high = pend_ne[1] && (cr[1] < i_weights.high);
        pick_med  = !pick_high && pend_ne[2] && (cr[2] < i_weights.mid);
        pick_low  = !pick_high && !pick_med && pend_ne[3] && (cr[3] <= i_weights.low);
        pick_any  = pend_ne != '0;

        for (int c = 0; c < NumCls; c++) begin
            p_credit[c] = cr[c];
        end
        p_total = tot0;
        tot1    = tot0;
        pick_cls = wpqa_pkg::ClsUrgent;
        if (pend_ne[0]) begin
            pick_cls = wpqa_pkg::ClsUrgent;
            for (int c = 0; c < NumCls; c++) begin
                p_credit[c] = r_credit[c];
            end
            p_total = r_total;
        end else if (pick_high) begin
            pick_cls    = wpqa_pkg::ClsHigh;
            p_credit[1] = sat_credit(cr[1]);
            if (p_credit[1] == i_weights.high) begin
                p_total = sat_total(tot0, TotW'(i_weights.high));
            end
        end else if (pick_med) begin
            pick_cls    = wpqa_pkg::ClsMedium;
            tot1        = sat_total(tot0, TotW'(i_weights.high));
            p_credit[1] = i_weights.high;
            p_credit[2] = sat_credit(cr[2]);
            p_total     = tot1;
            if (p_credit[2] == i_weights.mid) begin
                p_total = sat_total(tot1, TotW'(i_weights.mid));
            end
        end else if (pick_low) begin
            pick_cls    = wpqa_pkg::ClsLow;
            tot1        = sat_total(tot0,
                              TotW'(i_weights.high) + TotW'(i_weights.mid));
            p_credit[2] = i_weights.mid;
            p_credit[3] = sat_credit(cr[3]);
            p_total     = tot1;
            if (p_credit[3] == i_weights.low) begin
                p_total = sat_total(tot1, TotW'(i_weights.low));
            end
        end else if (pend_ne[1]) begin
            pick_cls = wpqa_pkg::ClsHigh;
        end else if (pend_ne[2]) begin
            pick_cls = wpqa_pkg::ClsMedium;
        end else begin
            pick_cls = wpqa_pkg::ClsLow;
        end
    end

    always_comb begin
        slot_sum = SlotW'(r_pend_head[cmd.cls]) + SlotW'(r_pend_cnt[cmd.cls]);
        if (slot_sum >= SlotW'(wpqa_pkg::PendingDepth)) begin
            slot_sum = slot_sum - SlotW'(wpqa_pkg::PendingDepth);
        end
        wr_slot = slot_sum[PendAw-1:0];
        if (r_pend_head[pick_cls] == PendAw'(wpqa_pkg::PendingDepth - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = r_pend_head[pick_cls] + PendAw'(1);
        end
        ram_waddr = {cmd.cls, wr_slot};
        ram_raddr = {pick_cls, r_pend_head[pick_cls]};
        launches  = cmd.is_done && (r_fl_cnt != 2'd0) && pick_any;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wpqa_pkg::BK_IDLE: begin
                if (start && launches) begin
                    n_state = wpqa_pkg::BK_LAUNCH;
                end
            end
            wpqa_pkg::BK_LAUNCH: begin
                n_state = wpqa_pkg::BK_IDLE;
            end
            default: begin
                n_state = wpqa_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_fl_tag  = r_fl_tag;
        n_fl_head = r_fl_head;
        n_fl_cnt  = r_fl_cnt;
        for (int c = 0; c < NumCls; c++) begin
            n_pend_head[c] = r_pend_head[c];
            n_pend_cnt[c]  = r_pend_cnt[c];
            n_credit[c]    = r_credit[c];
        end
        n_total     = r_total;
        n_del_tag   = r_del_tag;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        unique case (r_state)
            wpqa_pkg::BK_IDLE: begin
                if (start) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    if (!cmd.is_done) begin
                        if (r_fl_cnt != 2'd2) begin
                            n_fl_tag[r_fl_head ^ r_fl_cnt[0]] = cmd.tag;
                            n_fl_cnt           = r_fl_cnt + 2'd1;
                            n_out.launch_valid = 1'b1;
                            n_out.launch_tag   = cmd.tag;
                            if (cmd.cls != wpqa_pkg::ClsUrgent) begin
                                n_credit[cmd.cls] = sat_credit(r_credit[cmd.cls]);
                            end
                        end else if (r_pend_cnt[cmd.cls] !=
                                     PendCw'(wpqa_pkg::PendingDepth)) begin
                            ram_we = 1'b1;
                            n_pend_cnt[cmd.cls] = r_pend_cnt[cmd.cls] + PendCw'(1);
                        end else begin
                            n_out.overflow_flag = 1'b1;
                        end
                    end else if (r_fl_cnt == 2'd0) begin
                        n_out.underrun_flag = 1'b1;
                    end else begin
                        n_del_tag = r_fl_tag[r_fl_head];
                        n_fl_head = ~r_fl_head;
                        n_fl_cnt  = r_fl_cnt - 2'd1;
                        n_total   = p_total;
                        for (int c = 0; c < NumCls; c++) begin
                            n_credit[c] = p_credit[c];
                        end
                        if (pick_any) begin
                            n_pend_head[pick_cls] = head_inc;
                            n_pend_cnt[pick_cls]  = r_pend_cnt[pick_cls] - PendCw'(1);
                            n_out_valid           = 1'b0;
                        end else begin
                            n_out.delivered_valid = 1'b1;
                            n_out.delivered_tag   = r_fl_tag[r_fl_head];
                        end
                    end
                end
            end
            wpqa_pkg::BK_LAUNCH: begin
                n_fl_tag[r_fl_head ^ r_fl_cnt[0]] = ram_rdata;
                n_fl_cnt              = r_fl_cnt + 2'd1;
                n_out                 = '0;
                n_out.launch_valid    = 1'b1;
                n_out.launch_tag      = ram_rdata;
                n_out.delivered_valid = 1'b1;
                n_out.delivered_tag   = r_del_tag;
                n_out_valid           = 1'b1;
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wpqa_pkg::BK_IDLE;
            r_fl_head   <= 1'b0;
            r_fl_cnt    <= 2'd0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NumCls; c++) begin
                r_pend_head[c] <= '0;
                r_pend_cnt[c]  <= '0;
                r_credit[c]    <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_fl_head   <= n_fl_head;
            r_fl_cnt    <= n_fl_cnt;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            for (int c = 0; c < NumCls; c++) begin
                r_pend_head[c] <= n_pend_head[c];
                r_pend_cnt[c]  <= n_pend_cnt[c];
                r_credit[c]    <= n_credit[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fl_tag  <= n_fl_tag;
        r_del_tag <= n_del_tag;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ hw/rtl/weighted_priority_queue_arbiter_top.sv @@
// ----------------------------------------------------------------------------
// weighted_priority_queue_arbiter_top
// Urgent-first weighted round arbiter between class FIFOs and an in-flight
// FIFO of two entries, with an APB register port for the class weights.
// ----------------------------------------------------------------------------
// Commands enter on the input channel (i_in_valid, o_in_ready, i_in_item) and
// every command yields exactly one result item on the output channel
// (o_out_valid, i_out_ready, o_out_item). A transfer on either channel occurs
// when valid and ready are both high at a rising clock edge.
// A two-entry command queue decouples the input from the execution unit, so
// commands keep being accepted while a result waits for the receiver.
// An enqueue or a done that launches no waiting tag executes in the idle state
// and its result is registered in the output register. A done that launches a
// waiting tag also passes through the launch state, which waits on the
// registered read of the class FIFO memory before its result is registered.
// The execution unit takes a new command only in the idle state and only while
// the output register is free.
// When the receiver stalls, the result register holds, execution pauses and
// the input accepts at most two more commands before o_in_ready drops.
// Reset empties all FIFOs and clears credits and the round total; the weights
// return to 4, 2 and 1. Weights are written through the APB port at 0x0, 0x4 and 0x8;
// the user must write them only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module weighted_priority_queue_arbiter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  wpqa_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output wpqa_pkg::t_out_item                o_out_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wpqa_pkg::ApbAw-1:0]         paddr,
    input  logic [wpqa_pkg::ApbDw-1:0]         pwdata,
    output logic [wpqa_pkg::ApbDw-1:0]         prdata,
    output logic                               pready
);

    localparam int WW = wpqa_pkg::WeightW;

    wpqa_pkg::t_weights r_weights;
    wpqa_pkg::t_weights n_weights;
    wpqa_pkg::t_cmd_q   cmd_q;
    logic               cmd_pop;
    logic               cfg_wr;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb begin
        n_weights = r_weights;
        if (cfg_wr) begin
            unique case (reg_idx)
                wpqa_pkg::RegHighWeight:   n_weights.high = pwdata[WW-1:0];
                wpqa_pkg::RegMediumWeight: n_weights.mid  = pwdata[WW-1:0];
                wpqa_pkg::RegLowWeight:    n_weights.low  = pwdata[WW-1:0];
                default:                   n_weights      = r_weights;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            wpqa_pkg::RegHighWeight:   prdata = wpqa_pkg::ApbDw'(r_weights.high);
            wpqa_pkg::RegMediumWeight: prdata = wpqa_pkg::ApbDw'(r_weights.mid);
            wpqa_pkg::RegLowWeight:    prdata = wpqa_pkg::ApbDw'(r_weights.low);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights.high <= WW'(4);
            r_weights.mid  <= WW'(2);
            r_weights.low  <= WW'(1);
        end else begin
            r_weights <= n_weights;
        end
    end

    wpqa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item (i_in_item),
        .o_cmd_q   (cmd_q),
        .i_cmd_pop (cmd_pop)
    );

    wpqa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_q    (cmd_q),
        .o_cmd_pop  (cmd_pop),
        .i_weights  (r_weights),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted priority queue arbiter. A cycle-free
// model of the class queues, the in-flight queue, the credits and the round
// total predicts one outcome per accepted command. The monitor compares every
// outcome field by field, in order. Directed commands cover the corner cases.
// Random traffic, queue floods and a short high-class run follow, under several
// weight settings, with random sender gaps, receiver stalls and one long stall.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    wpqa_pkg::t_in_item            i_in_item   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    wpqa_pkg::t_out_item           o_out_item;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [wpqa_pkg::ApbAw-1:0]    paddr       = '0;
    logic [wpqa_pkg::ApbDw-1:0]    pwdata      = '0;
    logic [wpqa_pkg::ApbDw-1:0]    prdata;
    logic                          pready;

    weighted_priority_queue_arbiter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Model state.
    logic [wpqa_pkg::TagW-1:0]    pend_mem [wpqa_pkg::NumClasses][wpqa_pkg::PendingDepth];
    int unsigned                  pend_rd  [wpqa_pkg::NumClasses];
    int unsigned                  pend_cnt [wpqa_pkg::NumClasses];
    logic [wpqa_pkg::TagW-1:0]    fl_mem   [2];
    int unsigned                  fl_rd;
    int unsigned                  fl_cnt;
    logic [wpqa_pkg::CreditW-1:0] credit   [wpqa_pkg::NumClasses];
    logic [wpqa_pkg::TotalW-1:0]  rtotal;
    logic [wpqa_pkg::WeightW-1:0] w_high;
    logic [wpqa_pkg::WeightW-1:0] w_med;
    logic [wpqa_pkg::WeightW-1:0] w_low;

    wpqa_pkg::t_in_item  cmd_backlog[$];
    wpqa_pkg::t_out_item outcome_fifo[$];

    logic in_xfer = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   long_stall_asked = 0;
    int   long_stall_served = 0;
    int   long_stall_left = 0;
    int   rx_left = 0;
    t_rx_mode rx_mode = RX_OPEN;

    int mismatches = 0;
    int n_cmds = 0;
    int n_results = 0;
    int n_bypass = 0;
    int n_from_queue = 0;
    int n_drop = 0;
    int n_underrun = 0;
    int n_settings = 1;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void bump_credit(int c);
        if (credit[c] != wpqa_pkg::CreditMax) begin
            credit[c] = credit[c] + 1'b1;
        end
    endfunction

    function automatic void add_total(int unsigned v);
        int unsigned s;
        s = int'(rtotal) + v;
        rtotal = (s > wpqa_pkg::TotalMax) ? wpqa_pkg::TotalW'(wpqa_pkg::TotalMax)
                                          : s[wpqa_pkg::TotalW-1:0];
    endfunction

    // Returns NumClasses when no class has a waiting tag.
    function automatic int grant_waiting_class();
        int unsigned sum;
        if (pend_cnt[wpqa_pkg::ClsUrgent] > 0) return wpqa_pkg::ClsUrgent;
        sum = int'(w_high) + int'(w_med) + int'(w_low);
        if (rtotal >= sum) begin
            rtotal = '0;
            credit = '{default: '0};
        end
        if (pend_cnt[wpqa_pkg::ClsHigh] > 0 && credit[wpqa_pkg::ClsHigh] < w_high) begin
            bump_credit(wpqa_pkg::ClsHigh);
            if (credit[wpqa_pkg::ClsHigh] == w_high) add_total(w_high);
            return wpqa_pkg::ClsHigh;
        end
        if (pend_cnt[wpqa_pkg::ClsMedium] > 0 && credit[wpqa_pkg::ClsMedium] < w_med) begin
            add_total(w_high);
            credit[wpqa_pkg::ClsHigh] = w_high;
            bump_credit(wpqa_pkg::ClsMedium);
            if (credit[wpqa_pkg::ClsMedium] == w_med) add_total(w_med);
            return wpqa_pkg::ClsMedium;
        end
        if (pend_cnt[wpqa_pkg::ClsLow] > 0 && credit[wpqa_pkg::ClsLow] <= w_low) begin
            add_total(int'(w_med) + int'(w_high));
            credit[wpqa_pkg::ClsMedium] = w_med;
            bump_credit(wpqa_pkg::ClsLow);
            if (credit[wpqa_pkg::ClsLow] == w_low) add_total(w_low);
            return wpqa_pkg::ClsLow;
        end
        for (int c = 0; c < wpqa_pkg::NumClasses; c++) begin
            if (pend_cnt[c] > 0) return c;
        end
        return wpqa_pkg::NumClasses;
    endfunction

    function automatic wpqa_pkg::t_out_item arbitrate_cmd(wpqa_pkg::t_in_item it);
        wpqa_pkg::t_out_item       r;
        logic [wpqa_pkg::ClsW-1:0] cls;
        int                        c;
        r = '0;
        cls = it.queue_number[wpqa_pkg::ClsW-1:0];
        if (it.command == wpqa_pkg::CmdEnqueue) begin
            if (fl_cnt < 2) begin
                fl_mem[(fl_rd + fl_cnt) % 2] = it.request_tag;
                fl_cnt++;
                r.launch_valid = 1'b1;
                r.launch_tag = it.request_tag;
                if (cls != wpqa_pkg::ClsUrgent) bump_credit(cls);
            end else if (pend_cnt[cls] >= wpqa_pkg::PendingDepth) begin
                r.overflow_flag = 1'b1;
            end else begin
                pend_mem[cls][(pend_rd[cls] + pend_cnt[cls]) % wpqa_pkg::PendingDepth] =
                    it.request_tag;
                pend_cnt[cls]++;
            end
        end else if (fl_cnt == 0) begin
            r.underrun_flag = 1'b1;
        end else begin
            r.delivered_valid = 1'b1;
            r.delivered_tag = fl_mem[fl_rd];
            fl_rd = (fl_rd + 1) % 2;
            fl_cnt--;
            c = grant_waiting_class();
            if (c < wpqa_pkg::NumClasses) begin
                r.launch_valid = 1'b1;
                r.launch_tag = pend_mem[c][pend_rd[c]];
                pend_rd[c] = (pend_rd[c] + 1) % wpqa_pkg::PendingDepth;
                pend_cnt[c]--;
                fl_mem[(fl_rd + fl_cnt) % 2] = r.launch_tag;
                fl_cnt++;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void push_cmd(logic cmd, logic [2:0] qn,
                                     logic [wpqa_pkg::TagW-1:0] tag);
        wpqa_pkg::t_in_item it;
        it.command = cmd;
        it.queue_number = qn;
        it.request_tag = tag;
        cmd_backlog.push_back(it);
    endfunction

    function automatic void queue_mixed(int n);
        int done_pct;
        done_pct = $urandom_range(30, 60);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1, 100) <= done_pct) begin
                push_cmd(wpqa_pkg::CmdDone, 3'($urandom), 8'($urandom));
            end else begin
                push_cmd(wpqa_pkg::CmdEnqueue, 3'($urandom), 8'($urandom));
            end
        end
    endfunction

    // Fills one class queue past its depth behind a full in-flight queue.
    function automatic void queue_flood();
        logic [wpqa_pkg::ClsW-1:0] cls;
        cls = 2'($urandom);
        push_cmd(wpqa_pkg::CmdEnqueue, 3'($urandom), 8'($urandom));
        push_cmd(wpqa_pkg::CmdEnqueue, 3'($urandom), 8'($urandom));
        for (int i = 0; i < wpqa_pkg::PendingDepth + 2; i++) begin
            push_cmd(wpqa_pkg::CmdEnqueue, {1'($urandom), cls}, 8'($urandom));
        end
        for (int i = 0; i < wpqa_pkg::PendingDepth + 6; i++) begin
            push_cmd(wpqa_pkg::CmdDone, 3'($urandom), 8'($urandom));
        end
    endfunction

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || i_in_valid || outcome_fifo.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [wpqa_pkg::WeightW-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            wpqa_pkg::RegHighWeight:   w_high = val;
            wpqa_pkg::RegMediumWeight: w_med = val;
            wpqa_pkg::RegLowWeight:    w_low = val;
            default:                   ;
        endcase
    endtask

    // Sender: bursts of transfers separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_in_valid || in_xfer) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                i_in_item <= cmd_backlog.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall patterns, plus long holds on request.
    always @(negedge i_clk) begin
        if (long_stall_left > 0) begin
            long_stall_left--;
            i_out_ready <= 1'b0;
        end else if (long_stall_served < long_stall_asked) begin
            long_stall_served++;
            long_stall_left = 120;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(8, 40);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom);
                RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                RX_TOGGLE: i_out_ready <= !i_out_ready;
                default:   i_out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        wpqa_pkg::t_out_item want;
        in_xfer <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (outcome_fifo.size() == 0) begin
                    $error("result transfer with no outcome pending");
                    mismatches++;
                end else begin
                    want = outcome_fifo.pop_front();
                    check_field("launch_valid", want.launch_valid, o_out_item.launch_valid);
                    check_field("launch_tag", want.launch_tag, o_out_item.launch_tag);
                    check_field("delivered_valid", want.delivered_valid,
                                o_out_item.delivered_valid);
                    check_field("delivered_tag", want.delivered_tag, o_out_item.delivered_tag);
                    check_field("overflow_flag", want.overflow_flag, o_out_item.overflow_flag);
                    check_field("underrun_flag", want.underrun_flag, o_out_item.underrun_flag);
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = arbitrate_cmd(i_in_item);
                outcome_fifo.push_back(want);
                n_cmds++;
                if (want.launch_valid && !want.delivered_valid) n_bypass++;
                if (want.launch_valid && want.delivered_valid) n_from_queue++;
                if (want.overflow_flag) n_drop++;
                if (want.underrun_flag) n_underrun++;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        wpqa_pkg::t_weights plan[7];
        int                 flush;
        pend_rd = '{default: 0};
        pend_cnt = '{default: 0};
        fl_rd = 0;
        fl_cnt = 0;
        credit = '{default: '0};
        rtotal = '0;
        w_high = 8'd4;
        w_med = 8'd2;
        w_low = 8'd1;
        plan[0] = '{high: 8'd4, mid: 8'd2, low: 8'd1};
        plan[1] = '{high: 8'd1, mid: 8'd1, low: 8'd1};
        plan[2] = '{high: 8'd255, mid: 8'd255, low: 8'd255};
        plan[3] = '{high: 8'd255, mid: 8'd1, low: 8'd1};
        plan[4] = '{high: 8'd1, mid: 8'd255, low: 8'd1};
        plan[5] = '{high: 8'd1, mid: 8'd1, low: 8'd255};
        plan[6] = '{high: 8'($urandom_range(1, 255)), mid: 8'($urandom_range(1, 255)),
                    low: 8'($urandom_range(1, 255))};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner cases: done with nothing in flight, the extreme tags and queue
        // numbers, every class waiting, urgent ahead of the weighted round.
        push_cmd(wpqa_pkg::CmdDone, 3'd0, 8'h00);
        push_cmd(wpqa_pkg::CmdEnqueue, 3'd0, 8'h00);
        push_cmd(wpqa_pkg::CmdEnqueue, 3'd7, 8'hFF);
        push_cmd(wpqa_pkg::CmdEnqueue, 3'd1, 8'h11);
        push_cmd(wpqa_pkg::CmdEnqueue, 3'd2, 8'h22);
        push_cmd(wpqa_pkg::CmdEnqueue, 3'd3, 8'h33);
        push_cmd(wpqa_pkg::CmdEnqueue, 3'd5, 8'h55);
        push_cmd(wpqa_pkg::CmdEnqueue, 3'd6, 8'h66);
        push_cmd(wpqa_pkg::CmdEnqueue, 3'd4, 8'h44);
        for (int i = 0; i < 9; i++) push_cmd(wpqa_pkg::CmdDone, 3'd7, 8'hFF);

        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            if (ph > 0) begin
                apb_write(wpqa_pkg::RegHighWeight, plan[ph].high);
                apb_write(wpqa_pkg::RegMediumWeight, plan[ph].mid);
                apb_write(wpqa_pkg::RegLowWeight, plan[ph].low);
                n_settings++;
            end
            queue_mixed(30);
            if (ph == 1 || ph == 4) queue_flood();
            if (ph == 0) long_stall_asked++;
        end

        // Empty both queues, then run high class tags through a near-empty
        // in-flight queue.
        wait_idle();
        flush = fl_cnt;
        for (int c = 0; c < wpqa_pkg::NumClasses; c++) flush += pend_cnt[c];
        for (int i = 0; i < flush; i++) begin
            push_cmd(wpqa_pkg::CmdDone, 3'($urandom), 8'($urandom));
        end
        for (int i = 0; i < 32; i++) begin
            push_cmd(wpqa_pkg::CmdEnqueue, {1'($urandom), wpqa_pkg::ClsHigh}, 8'($urandom));
            push_cmd(wpqa_pkg::CmdDone, 3'($urandom), 8'($urandom));
        end
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (outcome_fifo.size() != 0) begin
            $error("%0d outcomes never arrived", outcome_fifo.size());
            mismatches++;
        end
        $display("Ran %0d commands and %0d results under %0d weight settings.",
                 n_cmds, n_results, n_settings);
        $display("Launches: %0d direct, %0d from class queues; %0d drops, %0d underruns.",
                 n_bypass, n_from_queue, n_drop, n_underrun);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/wpqa_pkg.sv
hw/rtl/wpqa_ram.sv
hw/rtl/wpqa_front.sv
hw/rtl/wpqa_back.sv
hw/rtl/weighted_priority_queue_arbiter_top.sv
verif/tb.sv
